// ===== src/telnet_option_negotiator_defines.svh =====
// ----------------------------------------------------------------------------
// telnet_option_negotiator_defines.svh
// Assertion macros for the TELNET option negotiator.
// ----------------------------------------------------------------------------
`ifndef TELNET_OPTION_NEGOTIATOR_DEFINES_SVH
`define TELNET_OPTION_NEGOTIATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Check that a condition implies another in the same cycle
`define TNO_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle
`define TNO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TNO_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define TNO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/tno_pkg.sv =====
// ----------------------------------------------------------------------------
// tno_pkg
// Shared codes, types and reply tables of the TELNET option negotiator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tno_pkg;

    // TELNET command codes
    localparam logic [7:0] TN_IAC  = 8'd255;
    localparam logic [7:0] TN_DONT = 8'd254;
    localparam logic [7:0] TN_DO   = 8'd253;
    localparam logic [7:0] TN_WONT = 8'd252;
    localparam logic [7:0] TN_WILL = 8'd251;
    localparam logic [7:0] TN_SB   = 8'd250;
    localparam logic [7:0] TN_SE   = 8'd240;
    localparam logic [7:0] TN_NULL = 8'd0;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEPT_A = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEPT_B = 2'd1;

    // Reset values of the accepted options (echo, suppress go ahead)
    localparam logic [7:0] ACCEPT_A_RESET = 8'd1;
    localparam logic [7:0] ACCEPT_B_RESET = 8'd3;

    // Parser modes
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_IAC     = 3'd1,
        MODE_CMD     = 3'd2,
        MODE_SB_OPT  = 3'd3,
        MODE_SB_BODY = 3'd4,
        MODE_SB_IAC  = 3'd5
    } mode_t;

    // Negotiation verb held between IAC verb and the option byte
    typedef enum logic [1:0] {
        VERB_DO   = 2'd0,
        VERB_WILL = 2'd1,
        VERB_WONT = 2'd2,
        VERB_DONT = 2'd3
    } verb_t;

    // Output jobs handed from the parser to the emitter
    typedef enum logic [1:0] {
        JOB_SHOW1  = 2'd0,  // display arg1
        JOB_SHOW2  = 2'd1,  // display IAC, then arg1
        JOB_REPLY3 = 2'd2,  // send IAC, arg0, arg1
        JOB_REPLY6 = 2'd3   // send IAC SB arg1 0 IAC SE
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] arg0;
        logic [7:0] arg1;
    } job_t;

    // Queue status seen by the top level
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    localparam int unsigned STEP_W = 3;

    // Byte of a job at a given output step
    function automatic logic [7:0] job_byte(input job_t j, input logic [STEP_W-1:0] step);
        logic [7:0] b;
        b = TN_IAC;
        unique case (j.kind)
            JOB_SHOW1:  b = j.arg1;
            JOB_SHOW2:  b = (step == 3'd0) ? TN_IAC : j.arg1;
            JOB_REPLY3:
            begin
                unique case (step)
                    3'd0:    b = TN_IAC;
                    3'd1:    b = j.arg0;
                    default: b = j.arg1;
                endcase
            end
            JOB_REPLY6:
            begin
                unique case (step)
                    3'd0:    b = TN_IAC;
                    3'd1:    b = TN_SB;
                    3'd2:    b = j.arg1;
                    3'd3:    b = TN_NULL;
                    3'd4:    b = TN_IAC;
                    default: b = TN_SE;
                endcase
            end
            default:    b = j.arg1;
        endcase
        return b;
    endfunction

    // Final step of a job
    function automatic logic job_last(input job_kind_t k, input logic [STEP_W-1:0] step);
        logic l;
        l = 1'b1;
        unique case (k)
            JOB_SHOW1:  l = 1'b1;
            JOB_SHOW2:  l = (step == 3'd1);
            JOB_REPLY3: l = (step == 3'd2);
            JOB_REPLY6: l = (step == 3'd5);
            default:    l = 1'b1;
        endcase
        return l;
    endfunction

    // Reply jobs go to the peer, show jobs to the display
    function automatic logic job_peer(input job_kind_t k);
        return (k == JOB_REPLY3) || (k == JOB_REPLY6);
    endfunction

endpackage

`default_nettype wire

// ===== src/tno_parser.sv =====
// ----------------------------------------------------------------------------
// tno_parser
// Front end: accepts received bytes, tracks the command state and posts one
// output job for every byte that causes results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tno_parser
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire  [7:0]                    in_byte,
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire  [tno_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire  [7:0]                    cfg_data,
    output logic                          push,
    input  wire                           push_ready,
    output tno_pkg::job_t                 push_job
);

    import tno_pkg::*;

    mode_t      mode_reg, mode_next;
    verb_t      verb_reg, verb_next;
    logic [7:0] sub_opt_reg, sub_opt_next;
    logic [7:0] accept_a_reg;
    logic [7:0] accept_b_reg;
    logic       accept;
    logic       has_job;
    logic       opt_ok;
    logic [7:0] verb_byte;

    assign cfg_ready = 1'b1;
    assign in_ready  = push_ready;
    assign accept    = in_valid && in_ready;
    assign push      = accept && has_job;

    // Store configuration writes; other indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accept_a_reg <= ACCEPT_A_RESET;
            accept_b_reg <= ACCEPT_B_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_ACCEPT_A)
                accept_a_reg <= cfg_data;
            else if (cfg_index == REG_ACCEPT_B)
                accept_b_reg <= cfg_data;
        end
    end

    // Advance the parser on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            verb_reg    <= VERB_DO;
            sub_opt_reg <= 8'd0;
        end
        else if (accept)
        begin
            mode_reg    <= mode_next;
            verb_reg    <= verb_next;
            sub_opt_reg <= sub_opt_next;
        end
    end

    // Next state
    always_comb
    begin
        mode_next    = MODE_IDLE;
        verb_next    = verb_reg;
        sub_opt_next = sub_opt_reg;
        unique case (mode_reg)
            MODE_IDLE:
                mode_next = (in_byte == TN_IAC) ? MODE_IAC : MODE_IDLE;
            MODE_IAC:
            begin
                priority if (in_byte == TN_DO)
                begin
                    mode_next = MODE_CMD;
                    verb_next = VERB_DO;
                end
                else if (in_byte == TN_WILL)
                begin
                    mode_next = MODE_CMD;
                    verb_next = VERB_WILL;
                end
                else if (in_byte == TN_WONT)
                begin
                    mode_next = MODE_CMD;
                    verb_next = VERB_WONT;
                end
                else if (in_byte == TN_DONT)
                begin
                    mode_next = MODE_CMD;
                    verb_next = VERB_DONT;
                end
                else if (in_byte == TN_SB)
                    mode_next = MODE_SB_OPT;
                else if (in_byte == TN_IAC)
                    mode_next = MODE_IAC;
                else
                    mode_next = MODE_IDLE;
            end
            MODE_CMD:
                mode_next = MODE_IDLE;
            MODE_SB_OPT:
            begin
                sub_opt_next = in_byte;
                mode_next    = (in_byte == TN_IAC) ? MODE_SB_IAC : MODE_SB_BODY;
            end
            MODE_SB_BODY:
                mode_next = (in_byte == TN_IAC) ? MODE_SB_IAC : MODE_SB_BODY;
            MODE_SB_IAC:
            begin
                priority if (in_byte == TN_SE)
                    mode_next = MODE_IDLE;
                else if (in_byte == TN_IAC)
                    mode_next = MODE_SB_IAC;
                else
                    mode_next = MODE_SB_BODY;
            end
            default:
                mode_next = (in_byte == TN_IAC) ? MODE_IAC : MODE_IDLE;
        endcase
    end

    // Pick the reply verb for a negotiation
    always_comb
    begin
        opt_ok = (in_byte == accept_a_reg) || (in_byte == accept_b_reg);
        unique case (verb_reg)
            VERB_DO:   verb_byte = opt_ok ? TN_WILL : TN_WONT;
            VERB_WILL: verb_byte = opt_ok ? TN_DO : TN_DONT;
            VERB_WONT: verb_byte = TN_DONT;
            VERB_DONT: verb_byte = TN_WONT;
            default:   verb_byte = TN_WONT;
        endcase
    end

    // Output job
    always_comb
    begin
        has_job       = 1'b0;
        push_job.kind = JOB_SHOW1;
        push_job.arg0 = verb_byte;
        push_job.arg1 = in_byte;
        unique case (mode_reg)
            MODE_IAC:
            begin
                if ((in_byte != TN_DO) && (in_byte != TN_WILL) && (in_byte != TN_WONT)
                    && (in_byte != TN_DONT) && (in_byte != TN_SB))
                begin
                    has_job       = 1'b1;
                    // A doubled IAC shows one IAC and waits for the next byte
                    push_job.kind = (in_byte == TN_IAC) ? JOB_SHOW1 : JOB_SHOW2;
                end
            end
            MODE_CMD:
            begin
                has_job       = 1'b1;
                push_job.kind = JOB_REPLY3;
            end
            MODE_SB_OPT, MODE_SB_BODY:
                has_job = 1'b0;
            MODE_SB_IAC:
            begin
                has_job       = (in_byte == TN_SE);
                push_job.kind = JOB_REPLY6;
                push_job.arg1 = sub_opt_reg;
            end
            default:
                has_job = (in_byte != TN_IAC);
        endcase
    end

endmodule

`default_nettype wire

// ===== src/tno_queue.sv =====
// ----------------------------------------------------------------------------
// tno_queue
// Short first-word-fall-through queue of output jobs between the parser and
// the emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tno_queue #(
    parameter int unsigned DEPTH = 4
)
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push,
    output logic              push_ready,
    input  tno_pkg::job_t     push_job,
    output logic              pop_valid,
    input  wire               pop,
    output tno_pkg::job_t     pop_job,
    output tno_pkg::q_stat_t  stat
);

    import tno_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign stat.full  = (count_reg == CNT_FULL);
    assign stat.empty = (count_reg == '0);
    assign push_ready = !stat.full;
    assign pop_valid  = !stat.empty;
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_job    = mem[rd_ptr_reg];

    // Write the job storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== src/tno_emitter.sv =====
// ----------------------------------------------------------------------------
// tno_emitter
// Back end: expands queued jobs into output bytes, one per cycle while the
// receiver is ready, through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tno_emitter
(
    input  wire            clk,
    input  wire            rst_n,
    input  wire            job_valid,
    output logic           job_pop,
    input  tno_pkg::job_t  job,
    output logic           out_valid,
    input  wire            out_ready,
    output logic [7:0]     out_byte,
    output logic           out_peer,
    output logic           out_last
);

    import tno_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic              valid_reg;
    logic [7:0]        byte_reg;
    logic              peer_reg;
    logic              last_reg;
    logic              load;
    logic              step_last;

    assign load      = job_valid && (!valid_reg || out_ready);
    assign step_last = job_last(job.kind, step_reg);
    assign job_pop   = load && step_last;

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_peer  = peer_reg;
    assign out_last  = last_reg;

    // Track the step within the current job and the output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                step_reg <= step_last ? '0 : step_reg + 1'b1;
            if (load)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    // Load the next output byte
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= job_byte(job, step_reg);
            peer_reg <= job_peer(job.kind);
            last_reg <= step_last;
        end
    end

endmodule

`default_nettype wire

// ===== src/telnet_option_negotiator.sv =====
// ----------------------------------------------------------------------------
// telnet_option_negotiator
// TELNET option negotiator: splits received bytes into display bytes and
// reply bytes for the peer.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle while the job queue has room. A byte
// that causes output posts one job; the emitter plays each job out at one
// byte per cycle while the receiver is ready (one byte for plain data, two
// for an IAC before a non-command byte, three for a negotiation reply, six
// for a subnegotiation reply), so the sustained input rate is one byte per
// cycle for plain data while the receiver is ready and is set by the emitter's
// output rate when replies pile up in the QUEUE_DEPTH-entry queue. Results
// pass through the job queue and the emitter's output register. Configuration
// writes are always taken; indexes other than 0 and 1 are ignored.
`timescale 1ns / 1ps
`default_nettype none
`include "telnet_option_negotiator_defines.svh"

module telnet_option_negotiator #(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  wire                             clk,
    input  wire                             rst_n,
    // Received bytes; s_tdata: [7:0] data_byte
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [7:0]                      s_tdata,
    // Results; m_tdata: [7:0] out_byte
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [7:0]                      m_tdata,
    // m_tuser: [0] to_peer
    output logic [0:0]                      m_tuser,
    output logic                            m_tlast,
    // Configuration writes
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [tno_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire  [7:0]                      cfg_data
);

    import tno_pkg::*;

    logic    q_push;
    logic    q_push_ready;
    job_t    q_push_job;
    logic    q_pop_valid;
    logic    q_pop;
    job_t    q_pop_job;
    q_stat_t q_stat;
    logic    out_peer;

    // Parse received bytes into jobs
    tno_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (q_push),
        .push_ready (q_push_ready),
        .push_job   (q_push_job)
    );

    // Buffer jobs between front and back
    tno_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_ready (q_push_ready),
        .push_job   (q_push_job),
        .pop_valid  (q_pop_valid),
        .pop        (q_pop),
        .pop_job    (q_pop_job),
        .stat       (q_stat)
    );

    // Play jobs out as output transfers
    tno_emitter u_emitter
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_pop_valid),
        .job_pop   (q_pop),
        .job       (q_pop_job),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_peer  (out_peer),
        .out_last  (m_tlast)
    );

    assign m_tuser[0] = out_peer;

    // Checks
    `TNO_ASSERT_SAME(a_no_push_when_full, clk, rst_n, q_stat.full, !q_push, "push into full queue")
    `TNO_ASSERT_SAME(a_no_pop_when_empty, clk, rst_n, q_stat.empty, !q_pop, "pop from empty queue")
    `TNO_ASSERT_NEXT(a_pop_marks_last, clk, rst_n, q_pop, m_tvalid && m_tlast, "job end not marked last")

endmodule

`default_nettype wire

// ===== bench/telnet_option_negotiator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_option_negotiator_test
// Self-checking bench for the TELNET option negotiator.
// ----------------------------------------------------------------------------
// A short scripted byte stream covers plain data, every negotiation verb,
// accepted and refused options, subnegotiation (with IAC as the option and
// doubled IACs before SE) and IAC followed by a non-command byte. Random
// phases follow, mostly well-formed commands with random content, under
// several accepted-option settings. Every result transfer is compared with
// an in-bench model of the parser.
// ----------------------------------------------------------------------------

module telnet_option_negotiator_test;

    import tno_pkg::*;

    // Register indexes the block has no register behind
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int STALL_PCT    = 20;
    localparam int HANG_LIMIT   = 2000;
    localparam int SETTLE       = 8;
    localparam int PHASE_BYTES  = 80;
    localparam int SCRIPT_LEN   = 27;

    // One byte leaving the block
    typedef struct packed {
        logic [7:0] out_byte;
        logic       to_peer;
        logic       last;
    } out_item_t;

    // Scripted byte, with its results typed in where they are plain to see
    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        logic [1:0] count;
        logic       peer;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } script_row_t;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = 8'd0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [7:0]             m_tdata;
    logic [0:0]             m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]             cfg_data  = 8'd0;

    // Parser model state
    mode_t      parse_mode;
    verb_t      held_verb;
    logic [7:0] sub_opt;
    logic [7:0] accept_a;
    logic [7:0] accept_b;

    out_item_t  step_bytes [$];
    out_item_t  bytes_due [$];

    int   mismatches      = 0;
    int   bytes_sent      = 0;
    int   results_checked = 0;
    int   cfg_writes      = 0;
    int   quiet_cycles    = 0;
    bit   steady          = 1'b0;

    logic [7:0] verb_codes [4] = '{TN_DO, TN_WILL, TN_WONT, TN_DONT};

    script_row_t script [SCRIPT_LEN] = '{
        '{8'h00,   1'b1, 2'd1, 1'b0, 8'h00,  8'h00,   8'h00},
        '{8'hFE,   1'b1, 2'd1, 1'b0, 8'hFE,  8'h00,   8'h00},
        '{TN_IAC,  1'b1, 2'd0, 1'b0, 8'h00,  8'h00,   8'h00},
        '{TN_DO,   1'b1, 2'd0, 1'b0, 8'h00,  8'h00,   8'h00},
        '{8'h01,   1'b1, 2'd3, 1'b1, TN_IAC, TN_WILL, 8'h01},
        '{TN_IAC,  1'b0, 2'd0, 1'b0, 8'h00,  8'h00,   8'h00},
        '{TN_WILL, 1'b0, 2'd0, 1'b0, 8'h00,  8'h00,   8'h00},
        '{8'h00,   1'b1, 2'd3, 1'b1, TN_IAC, TN_DONT, 8'h00},
        '{TN_IAC,  1'b0, 2'd0, 1'b0, 8'h00,  8'h00,   8'h00},
        '{TN_WONT, 1'b0, 2'd0, 1'b0, 8'h00,  8'h00,   8'h00},
        '{8'h01,   1'b0, 2'd0, 1'b0, 8'h00,  8'h00,   8'h00},
        '{TN_IAC,  1'b0, 2'd0, 1'b0, 8'h00,  8'h00,   8'h00},
        '{TN_DONT, 1'b0, 2'd0, 1'b0, 8'h00,  8'h00,   8'h00},
        '{8'hFF,   1'b1, 2'd3, 1'b1, TN_IAC, TN_WONT, 8'hFF},
        '{TN_IAC,  1'b0, 2'd0, 1'b0, 8'h00,  8'h00,   8'h00},
        '{TN_SB,   1'b0, 2'd0, 1'b0, 8'h00,  8'h00,   8'h00},
        '{8'h18,   1'b0, 2'd0, 1'b0, 8'h00,  8'h00,   8'h00},
        '{TN_IAC,  1'b0, 2'd0, 1'b0, 8'h00,  8'h00,   8'h00},
        '{TN_IAC,  1'b0, 2'd0, 1'b0, 8'h00,  8'h00,   8'h00},
        '{TN_SE,   1'b0, 2'd0, 1'b0, 8'h00,  8'h00,   8'h00},
        '{TN_IAC,  1'b0, 2'd0, 1'b0, 8'h00,  8'h00,   8'h00},
        '{TN_SB,   1'b0, 2'd0, 1'b0, 8'h00,  8'h00,   8'h00},
        '{TN_IAC,  1'b0, 2'd0, 1'b0, 8'h00,  8'h00,   8'h00},
        '{TN_SE,   1'b0, 2'd0, 1'b0, 8'h00,  8'h00,   8'h00},
        '{TN_IAC,  1'b0, 2'd0, 1'b0, 8'h00,  8'h00,   8'h00},
        '{TN_IAC,  1'b1, 2'd1, 1'b0, TN_IAC, 8'h00,   8'h00},
        '{TN_SE,   1'b1, 2'd2, 1'b0, TN_IAC, TN_SE,   8'h00}
    };

    telnet_option_negotiator DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Append one output byte of the current step
    function automatic void emit(input logic [7:0] b, input logic peer);
        out_item_t item;
        item.out_byte = b;
        item.to_peer  = peer;
        item.last     = 1'b0;
        step_bytes.push_back(item);
    endfunction

    // Byte seen with no command pending: arm on IAC, else show it
    function automatic void take_plain(input logic [7:0] b);
        if (b == TN_IAC)
            parse_mode = MODE_IAC;
        else
        begin
            parse_mode = MODE_IDLE;
            emit(b, 1'b0);
        end
    endfunction

    // Advance the parser model by one received byte
    function automatic void negotiate_byte(input logic [7:0] b);
        logic agreed;
        agreed = (b == accept_a) || (b == accept_b);
        step_bytes.delete();
        case (parse_mode)
            MODE_IAC:
            begin
                parse_mode = MODE_CMD;
                if (b == TN_DO)
                    held_verb = VERB_DO;
                else if (b == TN_WILL)
                    held_verb = VERB_WILL;
                else if (b == TN_WONT)
                    held_verb = VERB_WONT;
                else if (b == TN_DONT)
                    held_verb = VERB_DONT;
                else if (b == TN_SB)
                    parse_mode = MODE_SB_OPT;
                else
                begin
                    emit(TN_IAC, 1'b0);
                    take_plain(b);
                end
            end
            MODE_CMD:
            begin
                emit(TN_IAC, 1'b1);
                case (held_verb)
                    VERB_DO:   emit(agreed ? TN_WILL : TN_WONT, 1'b1);
                    VERB_WILL: emit(agreed ? TN_DO : TN_DONT, 1'b1);
                    VERB_WONT: emit(TN_DONT, 1'b1);
                    default:   emit(TN_WONT, 1'b1);
                endcase
                emit(b, 1'b1);
                parse_mode = MODE_IDLE;
            end
            MODE_SB_OPT:
            begin
                sub_opt    = b;
                parse_mode = (b == TN_IAC) ? MODE_SB_IAC : MODE_SB_BODY;
            end
            MODE_SB_BODY:
            begin
                if (b == TN_IAC)
                    parse_mode = MODE_SB_IAC;
            end
            MODE_SB_IAC:
            begin
                if (b == TN_SE)
                begin
                    emit(TN_IAC, 1'b1);
                    emit(TN_SB, 1'b1);
                    emit(sub_opt, 1'b1);
                    emit(TN_NULL, 1'b1);
                    emit(TN_IAC, 1'b1);
                    emit(TN_SE, 1'b1);
                    parse_mode = MODE_IDLE;
                end
                else if (b != TN_IAC)
                    parse_mode = MODE_SB_BODY;
            end
            default:
                take_plain(b);
        endcase
        if (step_bytes.size() > 0)
            step_bytes[$].last = 1'b1;
    endfunction

    // Offer one byte, with a random gap first unless steady, and return at its transfer
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while (!steady && $urandom_range(99) < STALL_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
    endtask

    // Send a byte and queue what the model says it causes
    task automatic feed(input logic [7:0] b);
        send_byte(b);
        negotiate_byte(b);
        foreach (step_bytes[i])
            bytes_due.push_back(step_bytes[i]);
    endtask

    // Write one configuration register
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_ACCEPT_A)
            accept_a = value;
        else if (idx == REG_ACCEPT_B)
            accept_b = value;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Hold the sender until every due byte is out, then let the block settle
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Random phase: mostly well-formed commands with random content
    task automatic run_random(input int target);
        logic [7:0] seq [$];
        int         start;
        int         roll;
        int         len;
        start = bytes_sent;
        while (bytes_sent - start < target)
        begin
            seq.delete();
            roll = $urandom_range(99);
            if (roll < 30)
            begin
                // plain text
                len = $urandom_range(4, 1);
                repeat (len) seq.push_back(8'($urandom_range(254)));
            end
            else if (roll < 60)
            begin
                // negotiation, option often one of the accepted ones
                seq.push_back(TN_IAC);
                seq.push_back(verb_codes[$urandom_range(3)]);
                case ($urandom_range(3))
                    0:       seq.push_back(accept_a);
                    1:       seq.push_back(accept_b);
                    default: seq.push_back(8'($urandom_range(255)));
                endcase
            end
            else if (roll < 80)
            begin
                // subnegotiation, now and then a long body
                seq.push_back(TN_IAC);
                seq.push_back(TN_SB);
                seq.push_back(8'($urandom_range(255)));
                len = ($urandom_range(7) == 0) ? $urandom_range(20, 12) : $urandom_range(5);
                repeat (len)
                begin
                    if ($urandom_range(5) == 0)
                        seq.push_back(TN_IAC);
                    seq.push_back(8'($urandom_range(255)));
                end
                if ($urandom_range(3) == 0)
                    seq.push_back(TN_IAC);
                seq.push_back(TN_IAC);
                seq.push_back(TN_SE);
            end
            else if (roll < 90)
            begin
                // IAC before an arbitrary byte
                seq.push_back(TN_IAC);
                seq.push_back(8'($urandom_range(255)));
            end
            else
                seq.push_back(8'($urandom_range(255)));
            foreach (seq[i])
                feed(seq[i]);
        end
        drain();
    endtask

    // Receiver: stall at random except in the steady stretch
    always @(negedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= STALL_PCT);
    end

    // Log one mismatch and count it
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("%0t ns: %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Compare each result transfer with the oldest due byte
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (bytes_due.size() == 0)
                report_mismatch("result with nothing due, out_byte", m_tdata, -1);
            else
            begin
                want = bytes_due.pop_front();
                if (m_tdata !== want.out_byte)
                    report_mismatch("out_byte", m_tdata, want.out_byte);
                if (m_tuser[0] !== want.to_peer)
                    report_mismatch("to_peer", m_tuser[0], want.to_peer);
                if (m_tlast !== want.last)
                    report_mismatch("last", m_tlast, want.last);
            end
            results_checked++;
        end
    end

    // Watchdog: give up after a long run of cycles with no transfer at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", HANG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        parse_mode = MODE_IDLE;
        held_verb  = VERB_DO;
        sub_opt    = 8'd0;
        accept_a   = ACCEPT_A_RESET;
        accept_b   = ACCEPT_B_RESET;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Scripted stream under the reset settings
        foreach (script[r])
        begin
            send_byte(script[r].data);
            negotiate_byte(script[r].data);
            if (script[r].typed)
            begin
                step_bytes.delete();
                for (int k = 0; k < int'(script[r].count); k++)
                begin
                    emit((k == 0) ? script[r].b0 : (k == 1) ? script[r].b1 : script[r].b2,
                         script[r].peer);
                end
                if (step_bytes.size() > 0)
                    step_bytes[$].last = 1'b1;
            end
            foreach (step_bytes[i])
                bytes_due.push_back(step_bytes[i]);
        end
        drain();

        run_random(PHASE_BYTES);

        // Extreme option codes, no idling on either side
        write_reg(REG_ACCEPT_A, 8'h00);
        write_reg(REG_ACCEPT_B, 8'hFF);
        steady = 1'b1;
        run_random(PHASE_BYTES);
        steady = 1'b0;

        // Swapped extremes; writes to unused indexes must change nothing
        write_reg(REG_ACCEPT_A, 8'hFF);
        write_reg(REG_ACCEPT_B, 8'h00);
        write_reg(REG_SPARE_2, 8'($urandom_range(255)));
        write_reg(REG_SPARE_3, 8'($urandom_range(255)));
        run_random(PHASE_BYTES);

        write_reg(REG_ACCEPT_A, 8'($urandom_range(255)));
        write_reg(REG_ACCEPT_B, 8'($urandom_range(255)));
        run_random(PHASE_BYTES);

        $display("Sent %0d bytes over four option settings, %0d register writes;",
                 bytes_sent, cfg_writes);
        $display("checked %0d output bytes of data, negotiation and subnegotiation replies.",
                 results_checked);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
